### hw/rtl/polar_scan_to_layered_points_unit_macros.svh
// assertion macros for the polar scan point unit
`ifndef POLAR_SCAN_TO_LAYERED_POINTS_UNIT_MACROS_SVH
`define POLAR_SCAN_TO_LAYERED_POINTS_UNIT_MACROS_SVH

// implication checked on every clock unless in reset
`define PSLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pslp_pkg.sv
// shared types, constants and tables for the polar scan point unit
`timescale 1ns / 1ps
package pslp_pkg;
    localparam int LAYERS_DEF      = 16;
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int CORDIC_ITERS    = 20;
    localparam int FRAC_BITS       = 10;
    // working width of the cordic vector: 20b range * gain plus fraction plus growth
    localparam int CW              = 34;
    localparam int AW              = 26;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam logic signed [AW-1:0] QUARTER_TURN = 26'sd4194304;
    localparam logic signed [AW-1:0] HALF_TURN    = 26'sd8388608;
    localparam logic signed [22:0] OUT_MIN = -23'sd1048576;
    localparam logic signed [22:0] OUT_MAX = 23'sd1048575;

    typedef enum logic [2:0] {
        REG_RANGE_MIN   = 3'd0,
        REG_RANGE_MAX   = 3'd1,
        REG_ANGLE_START = 3'd2,
        REG_ANGLE_STEP  = 3'd3,
        REG_Z_BASE      = 3'd4,
        REG_Z_STEP      = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [19:0]        win_lo;
        logic [19:0]        win_hi;
        logic signed [23:0] angle_start;
        logic signed [23:0] angle_step;
        logic signed [19:0] z_base;
        logic signed [15:0] z_step;
    } t_cfg;

    typedef struct packed {
        logic signed [20:0] x_pos;
        logic signed [20:0] y_pos;
    } t_xy;

    function automatic logic [AW-1:0] atan_turn(input logic [4:0] i);
        logic [AW-1:0] v;
        case (i)
            5'd0:  v = 26'd2097152;
            5'd1:  v = 26'd1238021;
            5'd2:  v = 26'd654136;
            5'd3:  v = 26'd332050;
            5'd4:  v = 26'd166669;
            5'd5:  v = 26'd83416;
            5'd6:  v = 26'd41718;
            5'd7:  v = 26'd20860;
            5'd8:  v = 26'd10430;
            5'd9:  v = 26'd5215;
            5'd10: v = 26'd2608;
            5'd11: v = 26'd1304;
            5'd12: v = 26'd652;
            5'd13: v = 26'd326;
            5'd14: v = 26'd163;
            5'd15: v = 26'd81;
            5'd16: v = 26'd41;
            5'd17: v = 26'd20;
            5'd18: v = 26'd10;
            5'd19: v = 26'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [20:0] sat21(input logic signed [22:0] v);
        if (v < OUT_MIN) return 21'sh100000;
        if (v > OUT_MAX) return 21'sh0FFFFF;
        return v[20:0];
    endfunction
endpackage

### hw/rtl/pslp_stream_if.sv
// valid/ready stream interface with a generic payload
`timescale 1ns / 1ps
interface pslp_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/pslp_front.sv
// front stages: index check, range window, angle multiply, gain multiply and quadrant fold
`timescale 1ns / 1ps
module pslp_front #(
    parameter int MAX_SAMPLES = pslp_pkg::MAX_SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [19:0]                i_range,
    input  logic [11:0]                i_index,
    input  pslp_pkg::t_cfg             i_cfg,
    output logic                       o_valid,
    output logic [pslp_pkg::CW-1:0]    o_x,
    output logic signed [pslp_pkg::AW-1:0] o_angle,
    output logic                       o_flip
);
    import pslp_pkg::*;

    logic                r_v1, r_v2;
    logic [19:0]         r_range1;
    logic [23:0]         r_prod1;
    logic [CW-1:0]       r_x2;
    logic signed [AW-1:0] r_a2;
    logic                r_f2;
    logic                w_ok;
    logic [23:0]         w_ang;
    logic signed [AW-1:0] w_a;
    logic [49:0]         w_g;

    // sample qualifies when in scan and inside the window
    assign w_ok = ({8'd0, i_index} < 20'(MAX_SAMPLES)) &&
                  (i_range >= i_cfg.win_lo) && (i_range <= i_cfg.win_hi);

    // stage 1: step times index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid && w_ok;
        end
        if (i_en) begin
            r_range1 <= i_range;
            r_prod1  <= 24'(i_cfg.angle_step * $signed({1'b0, i_index}));
        end
    end

    // stage 2: gain multiply and fold into a quarter turn
    assign w_ang = r_prod1 + i_cfg.angle_start;
    assign w_a   = AW'($signed(w_ang));
    assign w_g   = {30'd0, r_range1} * {20'd0, GAIN_Q30};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_x2 <= CW'((w_g + 50'd524288) >> 20);
            if (w_a > QUARTER_TURN) begin
                r_a2 <= w_a - HALF_TURN;
                r_f2 <= 1'b1;
            end else if (w_a < -QUARTER_TURN) begin
                r_a2 <= w_a + HALF_TURN;
                r_f2 <= 1'b1;
            end else begin
                r_a2 <= w_a;
                r_f2 <= 1'b0;
            end
        end
    end

    assign o_valid = r_v2;
    assign o_x     = r_x2;
    assign o_angle = r_a2;
    assign o_flip  = r_f2;
endmodule

### hw/rtl/pslp_cordic.sv
// pipelined rotation cordic, one iteration per stage, with round and saturate
`timescale 1ns / 1ps
module pslp_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [pslp_pkg::CW-1:0]        i_x,
    input  logic signed [pslp_pkg::AW-1:0] i_angle,
    input  logic                           i_flip,
    output logic                           o_valid,
    output pslp_pkg::t_xy                  o_xy
);
    import pslp_pkg::*;

    logic signed [CW-1:0] r_x [CORDIC_ITERS+1];
    logic signed [CW-1:0] r_y [CORDIC_ITERS+1];
    logic signed [AW-1:0] r_a [CORDIC_ITERS+1];
    logic                 r_f [CORDIC_ITERS+1];
    logic                 r_v [CORDIC_ITERS+1];
    logic                 r_vo;
    t_xy                  r_xy;
    logic signed [CW-1:0] w_rx, w_ry;
    logic signed [22:0]   w_nx, w_ny;

    assign r_x[0] = $signed(i_x);
    assign r_y[0] = '0;
    assign r_a[0] = i_angle;
    assign r_f[0] = i_flip;
    assign r_v[0] = i_valid;

    // one micro-rotation per stage, arithmetic shifts floor
    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_f[g+1] <= r_f[g];
                if (r_a[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_a[g+1] <= r_a[g] - $signed(atan_turn(5'(g)));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_a[g+1] <= r_a[g] + $signed(atan_turn(5'(g)));
                end
            end
        end
    end

    // round halves up, unfold, saturate
    assign w_rx = (r_x[CORDIC_ITERS] + CW'(512)) >>> FRAC_BITS;
    assign w_ry = (r_y[CORDIC_ITERS] + CW'(512)) >>> FRAC_BITS;
    assign w_nx = r_f[CORDIC_ITERS] ? -w_rx[22:0] : w_rx[22:0];
    assign w_ny = r_f[CORDIC_ITERS] ? -w_ry[22:0] : w_ry[22:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[CORDIC_ITERS];
        end
        if (i_en) begin
            r_xy.x_pos <= sat21(w_nx);
            r_xy.y_pos <= sat21(w_ny);
        end
    end

    assign o_valid = r_vo;
    assign o_xy    = r_xy;
endmodule

### hw/rtl/pslp_layers.sv
// layer expander: one sample into a run of layer points with running z
`timescale 1ns / 1ps
module pslp_layers #(
    parameter int LAYERS = pslp_pkg::LAYERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pslp_pkg::t_xy      i_xy,
    input  pslp_pkg::t_cfg     i_cfg,
    pslp_stream_if.source      m_out
);
    import pslp_pkg::*;
    localparam int NP = (LAYERS > 16) ? 16 : LAYERS;

    logic               r_busy;
    t_xy                r_xy;
    logic [3:0]         r_layer;
    logic signed [22:0] r_z;
    logic               r_ov;
    logic [67:0]        r_od;
    logic               w_last, w_emit, w_oacc;

    assign w_last  = (r_layer == 4'(NP - 1));
    assign w_oacc  = !r_ov || m_out.ready;
    assign w_emit  = r_busy && w_oacc;
    // take a new sample when idle or once the current one gives its last point
    assign o_ready = !r_busy || (w_emit && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_ready) r_busy <= i_valid;
            else if (w_emit && w_last) r_busy <= 1'b0;
            if (w_oacc) r_ov <= r_busy;
        end
        // running z stays exact in 23 bits for up to 16 layers
        if (o_ready && i_valid) begin
            r_xy    <= i_xy;
            r_layer <= '0;
            r_z     <= 23'(i_cfg.z_base);
        end else if (w_emit) begin
            r_layer <= r_layer + 4'd1;
            r_z     <= r_z + 23'(i_cfg.z_step);
        end
        if (w_emit) r_od <= {r_xy.x_pos, r_xy.y_pos, sat21(r_z), r_layer, w_last};
    end

    assign m_out.valid = r_ov;
    assign m_out.data  = r_od;
endmodule

### hw/rtl/polar_scan_to_layered_points_unit.sv
// top level of the polar scan to layered point unit
//
//  channel  dir  payload                                   beat
//  s_in     in   range_value[19:0] sample_index[11:0]      one sample
//  m_out    out  x y z[20:0] each, layer_num[3:0], last    one layer point
//  cfg      in   i_cfg_we, i_cfg_idx[2:0], i_cfg_data[23:0]
//
// a sample crosses 2 front stages and 21 cordic stages to reach the expander, which
// latches it and then registers its first point onto m_out
// the layer expander then emits min(LAYERS,16) points a sample, one point a cycle
// while m_out is not stalled, and takes the next sample as it emits the last point
// the pipe advances only when its head is empty or taken; stalls hold every stage
// reset is synchronous, active low, and restores the register defaults
`timescale 1ns / 1ps
module polar_scan_to_layered_points_unit #(
    parameter int LAYERS      = pslp_pkg::LAYERS_DEF,
    parameter int MAX_SAMPLES = pslp_pkg::MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    pslp_stream_if.sink   s_in,
    pslp_stream_if.source m_out
);
    import pslp_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_en, w_fv, w_cv, w_lr, w_ff;
    logic [CW-1:0]        w_fx;
    logic signed [AW-1:0] w_fa;
    t_xy                  w_xy;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_lo      <= '0;
            r_cfg.win_hi      <= 20'hFFFFF;
            r_cfg.angle_start <= '0;
            r_cfg.angle_step  <= '0;
            r_cfg.z_base      <= -20'sd2048;
            r_cfg.z_step      <= 16'sd205;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_RANGE_MIN:   r_cfg.win_lo      <= i_cfg_data[19:0];
                REG_RANGE_MAX:   r_cfg.win_hi      <= i_cfg_data[19:0];
                REG_ANGLE_START: r_cfg.angle_start <= i_cfg_data;
                REG_ANGLE_STEP:  r_cfg.angle_step  <= i_cfg_data;
                REG_Z_BASE:      r_cfg.z_base      <= i_cfg_data[19:0];
                REG_Z_STEP:      r_cfg.z_step      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves when its head is empty or taken
    assign w_en     = !w_cv || w_lr;
    assign s_in.ready = w_en;

    pslp_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(s_in.valid),
        .i_range(s_in.data[31:12]), .i_index(s_in.data[11:0]), .i_cfg(r_cfg),
        .o_valid(w_fv), .o_x(w_fx), .o_angle(w_fa), .o_flip(w_ff)
    );

    pslp_cordic u_cordic (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_fv), .i_x(w_fx),
        .i_angle(w_fa), .i_flip(w_ff), .o_valid(w_cv), .o_xy(w_xy)
    );

    pslp_layers #(.LAYERS(LAYERS)) u_layers (
        .i_clk, .i_rst_n, .i_valid(w_cv), .o_ready(w_lr), .i_xy(w_xy),
        .i_cfg(r_cfg), .m_out
    );
endmodule

### hw/rtl/pslp_checker.sv
// port-level checker for the polar scan point unit and its bind
`timescale 1ns / 1ps
`include "polar_scan_to_layered_points_unit_macros.svh"
module pslp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [67:0] out_data
);
    `PSLP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed under stall")
    `PSLP_ASSERT_NEXT(a_layer_seq, i_clk, i_rst_n, out_valid && out_ready && !out_data[0], !out_valid || out_data[4:1] == $past(out_data[4:1]) + 4'd1, "layer number skipped")
    `PSLP_ASSERT_NEXT(a_layer_first, i_clk, i_rst_n, out_valid && out_ready && out_data[0], !out_valid || out_data[4:1] == 4'd0, "new sample not at layer zero")
    `PSLP_ASSERT_NEXT(a_xy_same, i_clk, i_rst_n, out_valid && out_ready && !out_data[0], !out_valid || out_data[67:26] == $past(out_data[67:26]), "x or y changed within a sample")
endmodule

bind polar_scan_to_layered_points_unit pslp_checker u_pslp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .out_valid(m_out.valid),
    .out_ready(m_out.ready), .out_data(m_out.data)
);

### test/tb_polar_scan_to_layered_points_unit.sv
// testbench for the polar scan to layered point unit: predicted layer points vs. output beats
`timescale 1ns / 1ps
module tb_polar_scan_to_layered_points_unit;
    import pslp_pkg::*;

    typedef struct packed {
        logic signed [20:0] x_pos;
        logic signed [20:0] y_pos;
        logic signed [20:0] z_pos;
        logic [3:0]         layer_num;
        logic               last_point;
    } t_point;

    typedef struct packed {
        logic [19:0] range_value;
        logic [11:0] sample_index;
    } t_sample;

    localparam int  NUM_LAYERS   = 16;
    localparam int  DRAIN_CYCLES = 80;
    localparam int  CYCLE_LIMIT  = 400000;
    // index with no register behind it
    localparam t_reg_idx REG_NONE = t_reg_idx'(3'd7);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    pslp_stream_if #(.W(32)) s_in_if ();
    pslp_stream_if #(.W(68)) m_out_if ();

    polar_scan_to_layered_points_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (s_in_if.sink),
        .m_out      (m_out_if.source)
    );

    always #2 i_clk = ~i_clk;

    // local copy of the register file
    t_cfg cfg_copy;

    t_sample sample_queue[$];
    t_point  point_queue[$];
    t_sample sample_held;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      mismatch_count = 0;
    int      cycle_count = 0;

    longint atan_tab[CORDIC_ITERS] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    function automatic longint clamp21(input longint v);
        if (v < -1048576) return -1048576;
        if (v > 1048575) return 1048575;
        return v;
    endfunction

    // rotate (range, 0) by the beam angle with the fixed-point cordic
    function automatic void rotate_range(input longint rng, input logic [23:0] ang,
                                         output longint xo, output longint yo);
        longint a;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        a = longint'($signed(ang));
        flip = 1'b0;
        if (a > 4194304) begin
            a -= 8388608;
            flip = 1'b1;
        end else if (a < -4194304) begin
            a += 8388608;
            flip = 1'b1;
        end
        x = (rng * 64'd652032874 + (64'd1 << 19)) >>> 20;
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
                x -= dx;
                y += dy;
                a -= atan_tab[i];
            end else begin
                x += dx;
                y -= dy;
                a += atan_tab[i];
            end
        end
        x = (x + 512) >>> 10;
        y = (y + 512) >>> 10;
        if (flip) begin
            x = -x;
            y = -y;
        end
        xo = clamp21(x);
        yo = clamp21(y);
    endfunction

    // expected layer points of one accepted sample
    task automatic predict_points(input t_sample smp);
        logic [23:0] ang;
        longint x;
        longint y;
        longint z;
        t_point p;
        if (int'(smp.sample_index) >= MAX_SAMPLES_DEF)
            return;
        if (smp.range_value < cfg_copy.win_lo || smp.range_value > cfg_copy.win_hi)
            return;
        ang = cfg_copy.angle_start + cfg_copy.angle_step * {12'd0, smp.sample_index};
        rotate_range(longint'(smp.range_value), ang, x, y);
        for (int k = 0; k < NUM_LAYERS; k++) begin
            z = clamp21(longint'(cfg_copy.z_base) + k * longint'(cfg_copy.z_step));
            p.x_pos = x[20:0];
            p.y_pos = y[20:0];
            p.z_pos = z[20:0];
            p.layer_num = k[3:0];
            p.last_point = (k == NUM_LAYERS - 1);
            point_queue = {point_queue, p};
        end
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_in_if.valid <= 1'b0;
            s_in_if.data <= '0;
        end else begin
            if (s_in_if.valid && s_in_if.ready)
                predict_points(sample_held);
            if (!s_in_if.valid || s_in_if.ready) begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    sample_held = sample_queue.pop_front();
                    s_in_if.valid <= 1'b1;
                    s_in_if.data <= sample_held;
                end else begin
                    s_in_if.valid <= 1'b0;
                end
            end
        end
    end

    // point monitor
    always @(posedge i_clk) begin
        t_point got;
        t_point want;
        if (!i_rst_n) begin
            m_out_if.ready <= 1'b0;
        end else begin
            m_out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_out_if.valid && m_out_if.ready) begin
                got = m_out_if.data;
                if (point_queue.size() == 0) begin
                    $display("%0t: unexpected point beat %p", $time, got);
                    mismatch_count++;
                end else begin
                    want = point_queue.pop_front();
                    if (got.x_pos !== want.x_pos || got.y_pos !== want.y_pos
                            || got.z_pos !== want.z_pos || got.layer_num !== want.layer_num
                            || got.last_point !== want.last_point) begin
                        $display("%0t: expected %p actual %p", $time, want, got);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_RANGE_MIN:   cfg_copy.win_lo = val[19:0];
            REG_RANGE_MAX:   cfg_copy.win_hi = val[19:0];
            REG_ANGLE_START: cfg_copy.angle_start = val;
            REG_ANGLE_STEP:  cfg_copy.angle_step = val;
            REG_Z_BASE:      cfg_copy.z_base = val[19:0];
            REG_Z_STEP:      cfg_copy.z_step = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_done();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_sample(input logic [19:0] rng, input logic [11:0] idx);
        t_sample s;
        s.range_value = rng;
        s.sample_index = idx;
        sample_queue = {sample_queue, s};
    endtask

    // mostly in-window ranges, some anywhere
    task automatic add_random(input int n);
        logic [19:0] rng;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 80 && cfg_copy.win_lo <= cfg_copy.win_hi)
                rng = 20'($urandom_range(cfg_copy.win_hi, cfg_copy.win_lo));
            else
                rng = 20'($urandom);
            add_sample(rng, 12'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (sample_queue.size() > 0 || s_in_if.valid || point_queue.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        cfg_copy.win_lo = 20'd0;
        cfg_copy.win_hi = 20'hFFFFF;
        cfg_copy.angle_start = '0;
        cfg_copy.angle_step = '0;
        cfg_copy.z_base = -20'sd2048;
        cfg_copy.z_step = 16'sd205;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, range extremes
        add_sample(20'd0, 12'd0);
        add_sample(20'hFFFFF, 12'd4095);
        add_sample(20'd4096, 12'd100);
        add_sample(20'h55555, 12'hAAA);
        add_sample(20'hAAAAA, 12'h555);
        wait_idle();

        // fold boundaries: quarter turn, just past it, half-turn wrap
        write_reg(REG_ANGLE_START, 24'd4194304);
        write_reg(REG_ANGLE_STEP, 24'd4096);
        write_reg(REG_NONE, 24'hFFFFFF);
        write_done();
        add_sample(20'hFFFFF, 12'd0);
        add_sample(20'hFFFFF, 12'd1);
        add_sample(20'd1, 12'd1024);
        add_sample(20'd777, 12'd2047);
        add_sample(20'd777, 12'd2048);
        add_sample(20'd99999, 12'd3072);
        add_sample(20'hFFFFF, 12'd4095);
        add_sample(20'd0, 12'd4095);
        wait_idle();

        // narrow window with boundaries, negative z extremes, sender idling
        send_idle_pct = 51;
        write_reg(REG_RANGE_MIN, 24'd1000);
        write_reg(REG_RANGE_MAX, 24'd900000);
        write_reg(REG_ANGLE_START, 24'h800000);
        write_reg(REG_ANGLE_STEP, 24'h7FFFFF);
        write_reg(REG_Z_BASE, 24'h080000);
        write_reg(REG_Z_STEP, 24'h008000);
        write_done();
        add_sample(20'd999, 12'd5);
        add_sample(20'd1000, 12'd6);
        add_sample(20'd900000, 12'd7);
        add_sample(20'd900001, 12'd8);
        add_random(40);
        wait_idle();

        // positive z extremes, receiver stalling
        send_idle_pct = 0;
        recv_stall_pct = 51;
        write_reg(REG_RANGE_MIN, 24'd0);
        write_reg(REG_RANGE_MAX, 24'hFFFFF);
        write_reg(REG_ANGLE_START, 24'h7FFFFF);
        write_reg(REG_ANGLE_STEP, 24'($urandom));
        write_reg(REG_Z_BASE, 24'h07FFFF);
        write_reg(REG_Z_STEP, 24'h007FFF);
        write_done();
        add_random(40);
        wait_idle();

        // empty window: nothing comes out
        recv_stall_pct = 0;
        write_reg(REG_RANGE_MIN, 24'd500);
        write_reg(REG_RANGE_MAX, 24'd499);
        write_done();
        add_random(10);
        add_sample(20'd499, 12'd0);
        add_sample(20'd500, 12'd0);
        wait_idle();

        // random settings, both sides idling
        send_idle_pct = 12;
        recv_stall_pct = 12;
        write_reg(REG_RANGE_MIN, 24'($urandom_range(20000)));
        write_reg(REG_RANGE_MAX, 24'($urandom_range(1048575, 500000)));
        write_reg(REG_ANGLE_START, 24'($urandom));
        write_reg(REG_ANGLE_STEP, 24'($urandom));
        write_reg(REG_Z_BASE, 24'($urandom));
        write_reg(REG_Z_STEP, 24'($urandom));
        write_done();
        add_random(30);
        wait_idle();

        // random settings, no idling
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_RANGE_MIN, 24'd0);
        write_reg(REG_RANGE_MAX, 24'($urandom));
        write_reg(REG_ANGLE_STEP, 24'($urandom));
        write_reg(REG_Z_BASE, -24'sd2048);
        write_reg(REG_Z_STEP, 24'($urandom));
        write_done();
        add_random(30);
        wait_idle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### polar_scan_to_layered_points_unit.f
+incdir+hw/rtl
hw/rtl/pslp_pkg.sv
hw/rtl/pslp_stream_if.sv
hw/rtl/pslp_front.sv
hw/rtl/pslp_cordic.sv
hw/rtl/pslp_layers.sv
hw/rtl/polar_scan_to_layered_points_unit.sv
hw/rtl/pslp_checker.sv
test/tb_polar_scan_to_layered_points_unit.sv
